>>> hw/rtl/ecbs_pkg.sv
// Package for the error code blink sequencer: phase codes, register indexes,
// the fixed pulse pattern table and the rotating next-error search.
// Used by error_code_blink_sequencer_core; depends on nothing else.
package ecbs_pkg;

    localparam int NumCodes      = 9;
    localparam int SymbolsPerCode = 5;
    localparam int TickW         = 16;
    localparam int CodeW         = 4;
    localparam int SymW          = 3;
    localparam int CfgIndexW     = 3;

    // Configuration register indexes.
    localparam logic [CfgIndexW-1:0] REG_SHORT   = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_LONG    = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_PAUSE   = 3'd2;
    localparam logic [CfgIndexW-1:0] REG_GAP     = 3'd3;
    localparam logic [CfgIndexW-1:0] REG_FLASH   = 3'd4;
    localparam logic [CfgIndexW-1:0] REG_SUCCESS = 3'd5;

    localparam logic [TickW-1:0] SHORT_RESET   = 16'd200;
    localparam logic [TickW-1:0] LONG_RESET    = 16'd600;
    localparam logic [TickW-1:0] PAUSE_RESET   = 16'd200;
    localparam logic [TickW-1:0] GAP_RESET     = 16'd500;
    localparam logic [TickW-1:0] FLASH_RESET   = 16'd1000;
    localparam logic [TickW-1:0] SUCCESS_RESET = 16'd10000;

    // Input command codes.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Mode codes on the result.
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_CODE    = 2'd1;
    localparam logic [1:0] MODE_SEP     = 2'd2;
    localparam logic [1:0] MODE_SUCCESS = 2'd3;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_PULSE   = 7'b0000010,
        PH_PAUSE   = 7'b0000100,
        PH_GAP1    = 7'b0001000,
        PH_FLASH   = 7'b0010000,
        PH_GAP2    = 7'b0100000,
        PH_SUCCESS = 7'b1000000
    } t_phase;

    // Bit k set: symbol k of the code is a long pulse.
    localparam logic [SymbolsPerCode-1:0] PULSE_PATTERN [NumCodes] = '{
        5'h15, 5'h18, 5'h11, 5'h1C, 5'h07, 5'h0E, 5'h1F, 5'h00, 5'h0A
    };

    // First set bit of mask found searching upward from (from + 1), wrapping
    // at NumCodes. Returns 0 when the mask is empty.
    function automatic logic [CodeW-1:0] next_code(input logic [CodeW-1:0] from,
                                                   input logic [NumCodes-1:0] mask);
        logic [CodeW:0]   sum;
        logic [CodeW-1:0] idx;
        logic [CodeW-1:0] pick;
        pick = '0;
        for (int k = NumCodes; k >= 1; k--) begin
            sum = {1'b0, from} + (CodeW+1)'(k);
            if (sum >= (CodeW+1)'(NumCodes)) begin
                sum = sum - (CodeW+1)'(NumCodes);
            end
            idx = sum[CodeW-1:0];
            if (mask[idx]) begin
                pick = idx;
            end
        end
        return pick;
    endfunction

endpackage

>>> hw/rtl/error_code_blink_sequencer_core.sv
// Top level of the error code blink sequencer: stream input, stream output,
// configuration registers and the phase sequencer. Depends on ecbs_pkg.
//
// Usage: each input item is either a one-millisecond tick (tuser = 0) or a
// start (tuser = 1) carrying a 9-bit error mask in tdata. Every accepted item
// yields exactly one result item with the LED levels, the code being shown
// and the mode after that item. An empty mask lights green for success_ticks
// ticks and then goes idle; otherwise each set error, lowest first, blinks
// five red pulses from the pattern table, then gap, turquoise flash, gap, and
// the next set error follows, wrapping around until a new start arrives.
// The result is registered: it is valid the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver takes results; the phase
// update and the rotating search for the next error are both combinational
// between the state registers and the result register.
// The input is ready whenever the result register is empty or being taken,
// so a stalled receiver holds one result and stalls the input behind it.
// Reset (synchronous, active low) returns to idle with an empty mask and
// loads the default durations. Configuration writes take effect at once.
module error_code_blink_sequencer_core
    import ecbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,  // [8:0] error_flags, rest zero
    input  logic                 i_s_axis_tuser,  // [0] command
    // Result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata,  // [0] red LED, [1] green LED,
                                                  // [2] blue LED, [6:3] code_shown,
                                                  // [8:7] mode, rest zero
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [TickW-1:0]     i_cfg_wdata
);

    logic [TickW-1:0] r_short, r_long, r_pause, r_gap, r_flash, r_success;

    t_phase              r_phase, n_phase;
    logic [NumCodes-1:0] r_held_mask, n_held_mask;
    logic [CodeW-1:0]    r_code_index, n_code_index;
    logic [SymW-1:0]     r_symbol_index, n_symbol_index;
    logic [TickW-1:0]    r_tick_count, n_tick_count;

    logic                r_out_valid;
    logic [15:0]         r_out_data, n_out_data;

    logic                in_accept;
    logic                cmd;
    logic [NumCodes-1:0] flags;
    logic [TickW-1:0]    phase_len;
    logic [TickW:0]      tick_next;
    logic [SymbolsPerCode-1:0] pattern;
    logic                led_r, led_g, led_b;
    logic [CodeW-1:0]    shown;
    logic [1:0]          mode;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign cmd             = i_s_axis_tuser;
    assign flags           = i_s_axis_tdata[NumCodes-1:0];

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short   <= SHORT_RESET;
            r_long    <= LONG_RESET;
            r_pause   <= PAUSE_RESET;
            r_gap     <= GAP_RESET;
            r_flash   <= FLASH_RESET;
            r_success <= SUCCESS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SHORT:   r_short   <= i_cfg_wdata;
                REG_LONG:    r_long    <= i_cfg_wdata;
                REG_PAUSE:   r_pause   <= i_cfg_wdata;
                REG_GAP:     r_gap     <= i_cfg_wdata;
                REG_FLASH:   r_flash   <= i_cfg_wdata;
                REG_SUCCESS: r_success <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign pattern = PULSE_PATTERN[r_code_index];

    always_comb begin
        case (r_phase)
            PH_PULSE:   phase_len = pattern[r_symbol_index] ? r_long : r_short;
            PH_PAUSE:   phase_len = r_pause;
            PH_GAP1:    phase_len = r_gap;
            PH_GAP2:    phase_len = r_gap;
            PH_FLASH:   phase_len = r_flash;
            PH_SUCCESS: phase_len = r_success;
            default:    phase_len = TickW'(1);
        endcase
    end

    assign tick_next = {1'b0, r_tick_count} + (TickW+1)'(1);

    // Next state for the item at the input.
    always_comb begin
        n_phase        = r_phase;
        n_held_mask    = r_held_mask;
        n_code_index   = r_code_index;
        n_symbol_index = r_symbol_index;
        n_tick_count   = r_tick_count;
        if (cmd == CMD_START) begin
            n_held_mask    = flags;
            n_tick_count   = '0;
            n_symbol_index = '0;
            if (flags == '0) begin
                n_code_index = '0;
                n_phase      = PH_SUCCESS;
            end else begin
                n_code_index = next_code(CodeW'(NumCodes - 1), flags);
                n_phase      = PH_PULSE;
            end
        end else if (r_phase != PH_IDLE) begin
            if (tick_next >= {1'b0, phase_len}) begin
                n_tick_count = '0;
                case (r_phase)
                    PH_PULSE: n_phase = PH_PAUSE;
                    PH_PAUSE: begin
                        if (r_symbol_index == SymW'(SymbolsPerCode - 1)) begin
                            n_symbol_index = '0;
                            n_phase        = PH_GAP1;
                        end else begin
                            n_symbol_index = r_symbol_index + SymW'(1);
                            n_phase        = PH_PULSE;
                        end
                    end
                    PH_GAP1:  n_phase = PH_FLASH;
                    PH_FLASH: n_phase = PH_GAP2;
                    PH_GAP2: begin
                        n_code_index   = next_code(r_code_index, r_held_mask);
                        n_symbol_index = '0;
                        n_phase        = PH_PULSE;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end else begin
                n_tick_count = tick_next[TickW-1:0];
            end
        end
    end

    // Result fields follow the phase after the item.
    always_comb begin
        led_r = 1'b0;
        led_g = 1'b0;
        led_b = 1'b0;
        shown = '0;
        mode  = MODE_IDLE;
        case (n_phase)
            PH_PULSE: begin
                led_r = 1'b1;
                mode  = MODE_CODE;
                shown = n_code_index;
            end
            PH_PAUSE: begin
                mode  = MODE_CODE;
                shown = n_code_index;
            end
            PH_GAP1, PH_GAP2: begin
                mode  = MODE_SEP;
                shown = n_code_index;
            end
            PH_FLASH: begin
                led_g = 1'b1;
                led_b = 1'b1;
                mode  = MODE_SEP;
                shown = n_code_index;
            end
            PH_SUCCESS: begin
                led_g = 1'b1;
                mode  = MODE_SUCCESS;
            end
            default: ;
        endcase
        n_out_data = {7'b0, mode, shown, led_b, led_g, led_r};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_held_mask    <= '0;
            r_code_index   <= '0;
            r_symbol_index <= '0;
            r_tick_count   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase        <= n_phase;
                r_held_mask    <= n_held_mask;
                r_code_index   <= n_code_index;
                r_symbol_index <= n_symbol_index;
                r_tick_count   <= n_tick_count;
                r_out_valid    <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

    // A start with a nonempty mask lands on the first pulse of a set error.
    a_start_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && cmd == CMD_START && flags != '0
        |=> r_phase == PH_PULSE && r_held_mask[r_code_index] && r_symbol_index == '0)
        else $error("start did not select a set error");

    // While a code or separator runs, the code index points at a set error.
    a_code_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE && r_phase != PH_SUCCESS |-> r_held_mask[r_code_index])
        else $error("code index points at a clear error bit");

    // A tick while idle leaves the block idle.
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && cmd == CMD_TICK && r_phase == PH_IDLE |=> r_phase == PH_IDLE)
        else $error("tick left idle");

    // Every accepted item leaves a result waiting.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted item produced no result");

endmodule

>>> dv/error_code_blink_sequencer_core_tb.sv
// Self-checking testbench for error_code_blink_sequencer_core: a directed table, then random
// tick/start streams under several handshake idling profiles and duration settings.
// Depends on ecbs_pkg and the core; a local display model predicts every result item.
module error_code_blink_sequencer_core_tb;
    import ecbs_pkg::*;

    localparam int CycleLimit = 300000;
    localparam int DirRows    = 29;
    localparam int HoldCycles = 400;

    // Bit (code * 5 + symbol) set: that symbol of the code is a long pulse.
    localparam logic [44:0] LONG_MAP = {5'h0A, 5'h00, 5'h1F, 5'h0E, 5'h07,
                                        5'h1C, 5'h11, 5'h18, 5'h15};

    localparam logic [15:0] W_IDLE    = 16'h0000;
    localparam logic [15:0] W_SUCCESS = {7'd0, MODE_SUCCESS, 4'd0, 3'b010};

    typedef struct packed {
        logic [6:0] pad;
        logic [1:0] mode;
        logic [3:0] code;
        logic       blue;
        logic       green;
        logic       red;
    } t_led_word;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind      kind;
        logic           cmd;
        logic [8:0]     flags;
        logic [2:0]     reg_idx;
        logic [15:0]    reg_val;
        logic           typed;
        logic [15:0]    want;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [15:0]          i_s_axis_tdata;
    logic                 i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [15:0]          o_m_axis_tdata;
    logic                 i_cfg_we;
    logic [CfgIndexW-1:0] i_cfg_index;
    logic [TickW-1:0]     i_cfg_wdata;

    error_code_blink_sequencer_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Display model state and its copy of the duration registers.
    t_phase      disp_phase;
    logic [8:0]  disp_mask;
    logic [3:0]  disp_code;
    logic [2:0]  disp_sym;
    logic [15:0] disp_ticks;
    logic [15:0] dur_short, dur_long, dur_pause, dur_gap, dur_flash, dur_success;

    t_led_word   led_expect_q[$];
    t_led_word   led_want;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          sender_idle_pct = 0;
    int          stall_pct = 0;
    bit          pressure_start = 1'b0;
    logic        hold_off = 1'b0;
    t_dir_row    dir_tab [DirRows];

    function automatic logic [3:0] next_error(input logic [3:0] from, input logic [8:0] mask);
        int idx;
        for (int k = 1; k <= NumCodes; k++) begin
            idx = (int'(from) + k) % NumCodes;
            if (mask[idx]) return 4'(idx);
        end
        return 4'd0;
    endfunction

    function automatic t_led_word step_display(input logic cmd, input logic [8:0] flags);
        t_led_word   w;
        logic [16:0] next_count;
        logic [15:0] span;
        w = '0;
        if (cmd == CMD_START) begin
            disp_mask  = flags;
            disp_ticks = '0;
            disp_sym   = '0;
            if (flags == 9'd0) begin
                disp_code  = '0;
                disp_phase = PH_SUCCESS;
            end else begin
                disp_code  = next_error(4'(NumCodes - 1), flags);
                disp_phase = PH_PULSE;
            end
        end else if (disp_phase != PH_IDLE) begin
            case (disp_phase)
                PH_PULSE: span = LONG_MAP[int'(disp_code) * SymbolsPerCode + int'(disp_sym)]
                                 ? dur_long : dur_short;
                PH_PAUSE: span = dur_pause;
                PH_GAP1, PH_GAP2: span = dur_gap;
                PH_FLASH: span = dur_flash;
                default: span = dur_success;
            endcase
            // A zero duration compares like one: the first tick leaves the phase.
            next_count = {1'b0, disp_ticks} + 17'd1;
            if (next_count >= {1'b0, span}) begin
                disp_ticks = '0;
                case (disp_phase)
                    PH_PULSE: disp_phase = PH_PAUSE;
                    PH_PAUSE: begin
                        if (disp_sym == 3'(SymbolsPerCode - 1)) begin
                            disp_sym   = '0;
                            disp_phase = PH_GAP1;
                        end else begin
                            disp_sym   = disp_sym + 3'd1;
                            disp_phase = PH_PULSE;
                        end
                    end
                    PH_GAP1: disp_phase = PH_FLASH;
                    PH_FLASH: disp_phase = PH_GAP2;
                    PH_GAP2: begin
                        disp_code  = next_error(disp_code, disp_mask);
                        disp_sym   = '0;
                        disp_phase = PH_PULSE;
                    end
                    default: disp_phase = PH_IDLE;
                endcase
            end else begin
                disp_ticks = next_count[15:0];
            end
        end
        case (disp_phase)
            PH_PULSE: begin
                w.red  = 1'b1;
                w.mode = MODE_CODE;
                w.code = disp_code;
            end
            PH_PAUSE: begin
                w.mode = MODE_CODE;
                w.code = disp_code;
            end
            PH_GAP1, PH_GAP2: begin
                w.mode = MODE_SEP;
                w.code = disp_code;
            end
            PH_FLASH: begin
                w.green = 1'b1;
                w.blue  = 1'b1;
                w.mode  = MODE_SEP;
                w.code  = disp_code;
            end
            PH_SUCCESS: begin
                w.green = 1'b1;
                w.mode  = MODE_SUCCESS;
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [15:0] pick_duration();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'($urandom_range(20));
            default: return 16'($urandom_range(6, 1));
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [8:0] flags,
                             input logic typed, input logic [15:0] want);
        t_led_word predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {7'd0, flags};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = step_display(cmd, flags);
        led_expect_q.push_back(typed ? t_led_word'(want) : predicted);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_SHORT:   dur_short   = val;
            REG_LONG:    dur_long    = val;
            REG_PAUSE:   dur_pause   = val;
            REG_GAP:     dur_gap     = val;
            REG_FLASH:   dur_flash   = val;
            REG_SUCCESS: dur_success = val;
            default: ;
        endcase
    endtask

    // Stop offering items and wait until every expected result has been taken.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (led_expect_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n, input int sidle, input int rstall,
                             input bit press, input bit extreme);
        logic [8:0] mask;
        settle();
        for (int r = 0; r < 6; r++) begin
            write_reg(3'(r), extreme ? 16'hFFFF : pick_duration());
        end
        if (extreme) begin
            // Indexes past the last register are ignored by the block.
            write_reg(3'd6, 16'($urandom));
            write_reg(3'd7, 16'($urandom));
        end
        i_cfg_we        <= 1'b0;
        sender_idle_pct  = sidle;
        stall_pct        = rstall;
        if (press) pressure_start = 1'b1;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(extreme ? 14 : 29) == 0) begin
                case ($urandom_range(9))
                    0: mask = 9'd0;
                    1: mask = 9'h1FF;
                    2, 3: mask = 9'd1 << $urandom_range(8);
                    default: mask = 9'($urandom);
                endcase
                send_item(CMD_START, mask, 1'b0, W_IDLE);
            end else begin
                send_item(CMD_TICK, 9'($urandom), 1'b0, W_IDLE);
            end
        end
    endtask

    // Result checker and receiver-side ready generation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (led_expect_q.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected result item: tdata=%h", o_m_axis_tdata);
                end
                mismatch_count++;
            end else begin
                led_want = led_expect_q.pop_front();
                if (o_m_axis_tdata !== led_want) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch: expected r=%b g=%b b=%b code=%0d mode=%0d pad=%h,",
                                 led_want.red, led_want.green, led_want.blue,
                                 led_want.code, led_want.mode, led_want.pad);
                        $display("          actual   r=%b g=%b b=%b code=%0d mode=%0d pad=%h",
                                 o_m_axis_tdata[0], o_m_axis_tdata[1], o_m_axis_tdata[2],
                                 o_m_axis_tdata[6:3], o_m_axis_tdata[8:7],
                                 o_m_axis_tdata[15:9]);
                    end
                    mismatch_count++;
                end
            end
        end
        i_m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Long receiver hold-off so the result register fills and the input stalls.
    initial begin
        wait (pressure_start);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        bit in_cfg;
        in_cfg          = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_TICK;
        i_cfg_we        = 1'b0;
        i_cfg_index     = REG_SHORT;
        i_cfg_wdata     = '0;
        disp_phase  = PH_IDLE;
        disp_mask   = '0;
        disp_code   = '0;
        disp_sym    = '0;
        disp_ticks  = '0;
        dur_short   = SHORT_RESET;
        dur_long    = LONG_RESET;
        dur_pause   = PAUSE_RESET;
        dur_gap     = GAP_RESET;
        dur_flash   = FLASH_RESET;
        dur_success = SUCCESS_RESET;

        dir_tab = '{
            // Default durations: idle tick, empty mask, start while busy, top code.
            '{ROW_ITEM, CMD_TICK,  9'h1FF, REG_SHORT, 16'd0, 1'b1, W_IDLE},
            '{ROW_ITEM, CMD_START, 9'h000, REG_SHORT, 16'd0, 1'b1, W_SUCCESS},
            '{ROW_ITEM, CMD_TICK,  9'h000, REG_SHORT, 16'd0, 1'b1, W_SUCCESS},
            '{ROW_ITEM, CMD_START, 9'h1FF, REG_SHORT, 16'd0, 1'b1,
              {7'd0, MODE_CODE, 4'd0, 3'b001}},
            '{ROW_ITEM, CMD_START, 9'h100, REG_SHORT, 16'd0, 1'b1,
              {7'd0, MODE_CODE, 4'd8, 3'b001}},
            '{ROW_ITEM, CMD_TICK,  9'h0FF, REG_SHORT, 16'd0, 1'b1,
              {7'd0, MODE_CODE, 4'd8, 3'b001}},
            // Shortest durations, with a zero short pulse.
            '{ROW_CFG,  CMD_TICK,  9'h000, REG_SHORT,   16'd0, 1'b0, W_IDLE},
            '{ROW_CFG,  CMD_TICK,  9'h000, REG_LONG,    16'd1, 1'b0, W_IDLE},
            '{ROW_CFG,  CMD_TICK,  9'h000, REG_PAUSE,   16'd1, 1'b0, W_IDLE},
            '{ROW_CFG,  CMD_TICK,  9'h000, REG_GAP,     16'd1, 1'b0, W_IDLE},
            '{ROW_CFG,  CMD_TICK,  9'h000, REG_FLASH,   16'd1, 1'b0, W_IDLE},
            '{ROW_CFG,  CMD_TICK,  9'h000, REG_SUCCESS, 16'd1, 1'b0, W_IDLE},
            // A single error walks all five symbols, the separator, and repeats.
            '{ROW_ITEM, CMD_START, 9'h010, REG_SHORT, 16'd0, 1'b1,
              {7'd0, MODE_CODE, 4'd4, 3'b001}},
            '{ROW_ITEM, CMD_TICK,  9'h155, REG_SHORT, 16'd0, 1'b0, W_IDLE},
            '{ROW_ITEM, CMD_TICK,  9'h0AA, REG_SHORT, 16'd0, 1'b0, W_IDLE},
            '{ROW_ITEM, CMD_TICK,  9'h000, REG_SHORT, 16'd0, 1'b0, W_IDLE},
            '{ROW_ITEM, CMD_TICK,  9'h1FF, REG_SHORT, 16'd0, 1'b0, W_IDLE},
            '{ROW_ITEM, CMD_TICK,  9'h000, REG_SHORT, 16'd0, 1'b0, W_IDLE},
            '{ROW_ITEM, CMD_TICK,  9'h000, REG_SHORT, 16'd0, 1'b0, W_IDLE},
            '{ROW_ITEM, CMD_TICK,  9'h000, REG_SHORT, 16'd0, 1'b0, W_IDLE},
            '{ROW_ITEM, CMD_TICK,  9'h000, REG_SHORT, 16'd0, 1'b0, W_IDLE},
            '{ROW_ITEM, CMD_TICK,  9'h000, REG_SHORT, 16'd0, 1'b0, W_IDLE},
            '{ROW_ITEM, CMD_TICK,  9'h000, REG_SHORT, 16'd0, 1'b0, W_IDLE},
            '{ROW_ITEM, CMD_TICK,  9'h000, REG_SHORT, 16'd0, 1'b0, W_IDLE},
            '{ROW_ITEM, CMD_TICK,  9'h000, REG_SHORT, 16'd0, 1'b0, W_IDLE},
            '{ROW_ITEM, CMD_TICK,  9'h000, REG_SHORT, 16'd0, 1'b0, W_IDLE},
            // Empty mask with a one-tick success time drops back to idle.
            '{ROW_ITEM, CMD_START, 9'h000, REG_SHORT, 16'd0, 1'b1, W_SUCCESS},
            '{ROW_ITEM, CMD_TICK,  9'h000, REG_SHORT, 16'd0, 1'b1, W_IDLE},
            '{ROW_ITEM, CMD_TICK,  9'h1FF, REG_SHORT, 16'd0, 1'b1, W_IDLE}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DirRows; i++) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                if (!in_cfg) begin
                    settle();
                    in_cfg = 1'b1;
                end
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end else begin
                if (in_cfg) begin
                    i_cfg_we <= 1'b0;
                    in_cfg    = 1'b0;
                end
                send_item(dir_tab[i].cmd, dir_tab[i].flags, dir_tab[i].typed,
                          dir_tab[i].want);
            end
        end

        run_phase(350, 0, 0, 1'b0, 1'b0);
        run_phase(350, 72, 0, 1'b0, 1'b0);
        run_phase(350, 0, 72, 1'b0, 1'b0);
        run_phase(350, 30, 30, 1'b0, 1'b0);
        run_phase(350, 0, 0, 1'b1, 1'b0);
        run_phase(60, 30, 30, 1'b0, 1'b1);

        settle();
        repeat (8) @(posedge i_clk);
        if (led_expect_q.size() != 0) begin
            mismatch_count += led_expect_q.size();
        end
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
